>>> hdl/grid_first_fit_placement_defines.svh
// Assertion macros shared by the grid placement RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef GRID_FIRST_FIT_PLACEMENT_DEFINES_SVH
`define GRID_FIRST_FIT_PLACEMENT_DEFINES_SVH

// same-cycle implication
`define GFFP_ASSERT_SAME(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication
`define GFFP_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

>>> hdl/gffp_pkg.sv
// Shared types, constants and codes for the grid placement block.
// No dependencies.
package gffp_pkg;

    localparam int MAX_GRID_COLUMNS = 64;
    localparam int MAX_GRID_ROWS    = 64;
    localparam int COL_W   = $clog2(MAX_GRID_COLUMNS);
    localparam int ROW_W   = $clog2(MAX_GRID_ROWS);
    localparam int CNT_W   = $clog2(((MAX_GRID_COLUMNS > MAX_GRID_ROWS) ?
                                     MAX_GRID_COLUMNS : MAX_GRID_ROWS) + 1);
    localparam int PIX_W   = 12;
    localparam int SUM_W   = 13;
    localparam int SPC_W   = 8;
    localparam int OUT_W   = 13;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 3;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NOROOM = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER   = 3'd5;

    // divider operand selects
    localparam int DSEL_W = 3;
    localparam logic [DSEL_W-1:0] DIV_AW = 3'd0;
    localparam logic [DSEL_W-1:0] DIV_AH = 3'd1;
    localparam logic [DSEL_W-1:0] DIV_DX = 3'd2;
    localparam logic [DSEL_W-1:0] DIV_EX = 3'd3;
    localparam logic [DSEL_W-1:0] DIV_DY = 3'd4;
    localparam logic [DSEL_W-1:0] DIV_EY = 3'd5;
    localparam logic [DSEL_W-1:0] DIV_RW = 3'd6;
    localparam logic [DSEL_W-1:0] DIV_RH = 3'd7;

    // datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
    localparam logic [OP_W-1:0] OP_DIV_START = 5'd2;
    localparam logic [OP_W-1:0] OP_DIV_STORE = 5'd3;
    localparam logic [OP_W-1:0] OP_MARK_INIT = 5'd4;
    localparam logic [OP_W-1:0] OP_MARK_RD   = 5'd5;
    localparam logic [OP_W-1:0] OP_MARK_WR   = 5'd6;
    localparam logic [OP_W-1:0] OP_SCAN_INIT = 5'd7;
    localparam logic [OP_W-1:0] OP_ACC_RD    = 5'd8;
    localparam logic [OP_W-1:0] OP_ACC_OR    = 5'd9;
    localparam logic [OP_W-1:0] OP_WIN_FOUND = 5'd10;
    localparam logic [OP_W-1:0] OP_NEXT_A    = 5'd11;
    localparam logic [OP_W-1:0] OP_NEXT_B    = 5'd12;
    localparam logic [OP_W-1:0] OP_COL_RD    = 5'd13;
    localparam logic [OP_W-1:0] OP_COL_STEP  = 5'd14;
    localparam logic [OP_W-1:0] OP_COL_FOUND = 5'd15;
    localparam logic [OP_W-1:0] OP_NEXT_COL  = 5'd16;
    localparam logic [OP_W-1:0] OP_FINISH    = 5'd17;

    typedef struct packed {
        logic             mode;
        logic             new_layout;
        logic [PIX_W-1:0] rect_left;
        logic [PIX_W-1:0] rect_top;
        logic [PIX_W-1:0] rect_width;
        logic [PIX_W-1:0] rect_height;
    } item_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DSEL_W-1:0] dsel;
        logic              status_we;
        logic [STAT_W-1:0] status;
    } cmd_t;

    typedef struct packed {
        logic s_zero;
        logic div_done;
        logic mode;
        logic fresh;
        logic order;
        logic neg;
        logic empty;
        logic oob;
        logic no_room;
        logic acc_free;
        logic row_free;
        logic r_at_end;
        logic a_last;
        logic b_last;
        logic r_last;
        logic run_hit;
        logic mark_last;
        logic out_free;
    } sts_t;

endpackage

>>> hdl/gffp_if.sv
// Request and response channel interfaces for the grid placement block.
// Depends on gffp_pkg.
interface gffp_req_if;
    import gffp_pkg::*;
    logic             valid;
    logic             ready;
    logic             mode;
    logic             new_layout;
    logic [PIX_W-1:0] rect_left;
    logic [PIX_W-1:0] rect_top;
    logic [PIX_W-1:0] rect_width;
    logic [PIX_W-1:0] rect_height;
    modport source (output valid, mode, new_layout, rect_left, rect_top, rect_width,
                    rect_height, input ready);
    modport sink (input valid, mode, new_layout, rect_left, rect_top, rect_width,
                  rect_height, output ready);
endinterface

interface gffp_rsp_if;
    import gffp_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [OUT_W-1:0]  placed_left;
    logic [OUT_W-1:0]  placed_top;
    modport source (output valid, status, placed_left, placed_top, input ready);
    modport sink (input valid, status, placed_left, placed_top, output ready);
endinterface

>>> hdl/grid_first_fit_placement.sv
// Top level of the grid first-fit placement block: channels and config port.
// Depends on gffp_pkg, gffp_if, gffp_ctrl and gffp_dp.
//
// Usage
//   req carries one request: mode 0 reserves the anchors under an existing
//   rectangle, mode 1 searches first-fit for room for a new one and reserves
//   it; new_layout clears the grid and resizes it from the current config.
//   rsp returns one result per request: status, and the placed position.
//   cfg_we/cfg_index/cfg_data write registers 0..5 (spacing, area left, top,
//   width, height, search order); write only while no request is in flight.
// Sequencing
//   One request at a time. Each quotient comes from a serial divider: up to
//   4 per request, plus 2 more on a new layout. A mark then reads and writes
//   the RAM word of each grid row covered, read first, then write. A place
//   scan reads one grid row at a time: column order rescans the rows of
//   each candidate column, row order ORs h+1 rows per candidate row and
//   then tests each candidate column against the result.
// Reset clears the grid valid bits, so the whole grid reads as free at once;
// config returns to 20, 0, 0, 640, 360, 0 and the grid size to zero.
// A stalled rsp holds its result; the next request is still accepted and
// runs, and it waits only at completion until the output register is free.
module grid_first_fit_placement (
    input  logic                          clk,
    input  logic                          rst_n,
    gffp_req_if.sink                      req,
    gffp_rsp_if.source                    rsp,
    input  logic                          cfg_we,
    input  logic [gffp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gffp_pkg::PIX_W-1:0]     cfg_data
);
    import gffp_pkg::*;

    item_t item;
    cmd_t  cmd;
    sts_t  sts;

    // pack the request fields
    assign item.mode        = req.mode;
    assign item.new_layout  = req.new_layout;
    assign item.rect_left   = req.rect_left;
    assign item.rect_top    = req.rect_top;
    assign item.rect_width  = req.rect_width;
    assign item.rect_height = req.rect_height;

    gffp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gffp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item       (item),
        .cmd        (cmd),
        .out_ready  (rsp.ready),
        .sts        (sts),
        .out_valid  (rsp.valid),
        .out_status (rsp.status),
        .out_left   (rsp.placed_left),
        .out_top    (rsp.placed_top)
    );
endmodule

>>> hdl/gffp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gffp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/gffp_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on gffp_pkg.
module gffp_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [gffp_pkg::SUM_W-1:0] dividend,
    input  logic [gffp_pkg::SPC_W-1:0] divisor,
    output logic                      done,
    output logic [gffp_pkg::SUM_W-1:0] quotient
);
    import gffp_pkg::*;

    localparam int CNT_BITS = $clog2(SUM_W + 1);

    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [SPC_W-1:0]    rem_reg;
    logic [SPC_W-1:0]    dvs_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [SPC_W:0]      trial;
    logic                fits;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_BITS'(SUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? SPC_W'(trial - {1'b0, dvs_reg}) : trial[SPC_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

>>> hdl/gffp_dp.sv
// Datapath: configuration, item registers, divider, anchor RAM, scan counters.
// Depends on gffp_pkg, gffp_div and gffp_ram.
module gffp_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gffp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gffp_pkg::PIX_W-1:0]     cfg_data,
    input  gffp_pkg::item_t               item,
    input  gffp_pkg::cmd_t                cmd,
    input  logic                          out_ready,
    output gffp_pkg::sts_t                sts,
    output logic                          out_valid,
    output logic [gffp_pkg::STAT_W-1:0]    out_status,
    output logic [gffp_pkg::OUT_W-1:0]     out_left,
    output logic [gffp_pkg::OUT_W-1:0]     out_top
);
    import gffp_pkg::*;

    localparam int PROD_W = COL_W + SPC_W + 1;
    localparam logic [MAX_GRID_COLUMNS-1:0] ONES = '1;

    function automatic logic window_free(input logic [MAX_GRID_COLUMNS-1:0] word,
                                         input logic [COL_W-1:0] a,
                                         input logic [CNT_W-1:0] wa);
        logic [CNT_W-1:0]            len;
        logic [MAX_GRID_COLUMNS-1:0] m;
        len = wa + CNT_W'(1);
        m = ~(ONES << len);
        return ((word >> a) & m) == '0;
    endfunction

    function automatic logic [MAX_GRID_COLUMNS-1:0] span_mask(input logic [COL_W-1:0] x0,
                                                            input logic [COL_W-1:0] x1);
        logic [CNT_W-1:0] hi;
        hi = CNT_W'(x1) + CNT_W'(1);
        return (ONES << x0) & ~(ONES << hi);
    endfunction

    function automatic logic [OUT_W-1:0] place_pix(input logic [COL_W-1:0] idx,
                                                  input logic [SPC_W-1:0] s,
                                                  input logic [PIX_W-1:0] org);
        logic [PROD_W-1:0] v;
        v = PROD_W'(idx) * PROD_W'(s) + PROD_W'(org);
        return (v > PROD_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
    endfunction

    // configuration
    logic [SPC_W-1:0] spacing_reg;
    logic [PIX_W-1:0] area_left_reg, area_top_reg, area_width_reg, area_height_reg;
    logic             order_reg;

    // item and derived values
    item_t            item_reg;
    logic [CNT_W-1:0] cols_reg, rows_reg;
    logic [SUM_W-1:0] x0_reg, x1_reg, y0_reg, y1_reg, wa_reg, ha_reg;
    logic [COL_W-1:0] a_reg;
    logic [ROW_W-1:0] b_reg, r_reg, ptr_reg;
    logic [CNT_W-1:0] run_reg;
    logic [MAX_GRID_COLUMNS-1:0] acc_reg;
    logic [MAX_GRID_ROWS-1:0]    row_valid_reg;
    logic                        rvalid_reg;
    logic [STAT_W-1:0]           status_reg;
    logic                        out_valid_reg;
    logic [STAT_W-1:0]           out_status_reg;
    logic [OUT_W-1:0]            out_left_reg, out_top_reg;

    logic [PIX_W-1:0] dx, dy;
    logic [SUM_W-1:0] ex_raw, ey_raw, ex, ey, dividend, quotient;
    logic             shrink_x, shrink_y, div_done;
    logic [ROW_W-1:0] raddr;
    logic [MAX_GRID_COLUMNS-1:0] ram_rdata, rowdata, wdata;
    logic [CNT_W-1:0] wa_n, ha_n;
    logic [CNT_W-1:0] q_cols, q_rows;

    assign dx = item_reg.rect_left - area_left_reg;
    assign dy = item_reg.rect_top - area_top_reg;
    assign ex_raw = SUM_W'(dx) + SUM_W'(item_reg.rect_width);
    assign ey_raw = SUM_W'(dy) + SUM_W'(item_reg.rect_height);
    assign shrink_x = (SUM_W'(item_reg.rect_left) + SUM_W'(item_reg.rect_width) ==
                       SUM_W'(area_left_reg) + SUM_W'(area_width_reg)) && (ex_raw != '0);
    assign shrink_y = (SUM_W'(item_reg.rect_top) + SUM_W'(item_reg.rect_height) ==
                       SUM_W'(area_top_reg) + SUM_W'(area_height_reg)) && (ey_raw != '0);
    assign ex = ex_raw - SUM_W'(shrink_x);
    assign ey = ey_raw - SUM_W'(shrink_y);

    always_comb
    begin
        case (cmd.dsel)
            DIV_AW:  dividend = SUM_W'(area_width_reg);
            DIV_AH:  dividend = SUM_W'(area_height_reg);
            DIV_DX:  dividend = SUM_W'(dx);
            DIV_EX:  dividend = ex;
            DIV_DY:  dividend = SUM_W'(dy);
            DIV_EY:  dividend = ey;
            DIV_RW:  dividend = SUM_W'(item_reg.rect_width);
            DIV_RH:  dividend = SUM_W'(item_reg.rect_height);
            default: dividend = '0;
        endcase
    end

    gffp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_DIV_START),
        .dividend (dividend),
        .divisor  (spacing_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign q_cols = (quotient > SUM_W'(MAX_GRID_COLUMNS)) ? CNT_W'(MAX_GRID_COLUMNS)
                                                         : quotient[CNT_W-1:0];
    assign q_rows = (quotient > SUM_W'(MAX_GRID_ROWS)) ? CNT_W'(MAX_GRID_ROWS)
                                                      : quotient[CNT_W-1:0];

    // anchor rows: one RAM word per grid row, rows never written read as free
    assign raddr   = (cmd.op == OP_MARK_RD) ? ptr_reg : r_reg;
    assign rowdata = rvalid_reg ? ram_rdata : '0;
    assign wdata   = rowdata | span_mask(x0_reg[COL_W-1:0], x1_reg[COL_W-1:0]);

    gffp_ram #(
        .WIDTH (MAX_GRID_COLUMNS),
        .DEPTH (MAX_GRID_ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.op == OP_MARK_WR),
        .waddr (ptr_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign wa_n = wa_reg[CNT_W-1:0];
    assign ha_n = ha_reg[CNT_W-1:0];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg     <= SPC_W'(20);
            area_left_reg   <= '0;
            area_top_reg    <= '0;
            area_width_reg  <= PIX_W'(640);
            area_height_reg <= PIX_W'(360);
            order_reg       <= 1'b0;
            cols_reg        <= '0;
            rows_reg        <= '0;
            row_valid_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SPACING: spacing_reg     <= cfg_data[SPC_W-1:0];
                    CFG_LEFT:    area_left_reg   <= cfg_data;
                    CFG_TOP:     area_top_reg    <= cfg_data;
                    CFG_WIDTH:   area_width_reg  <= cfg_data;
                    CFG_HEIGHT:  area_height_reg <= cfg_data;
                    CFG_ORDER:   order_reg       <= cfg_data[0];
                    default:     ;
                endcase
            end
            if (cmd.op == OP_LOAD && item.new_layout)
            begin
                row_valid_reg <= '0;
                cols_reg      <= '0;
                rows_reg      <= '0;
            end
            if (cmd.op == OP_DIV_STORE && cmd.dsel == DIV_AW)
            begin
                cols_reg <= q_cols;
            end
            if (cmd.op == OP_DIV_STORE && cmd.dsel == DIV_AH)
            begin
                rows_reg <= q_rows;
            end
            if (cmd.op == OP_MARK_WR)
            begin
                row_valid_reg[ptr_reg] <= 1'b1;
            end
            if (cmd.op == OP_FINISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rvalid_reg <= row_valid_reg[raddr];
        if (cmd.status_we)
        begin
            status_reg <= cmd.status;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                item_reg   <= item;
                status_reg <= STATUS_DONE;
            end
            OP_DIV_STORE:
            begin
                case (cmd.dsel)
                    DIV_DX:  x0_reg <= quotient;
                    DIV_EX:  x1_reg <= quotient;
                    DIV_DY:  y0_reg <= quotient;
                    DIV_EY:  y1_reg <= quotient;
                    DIV_RW:  wa_reg <= quotient;
                    DIV_RH:  ha_reg <= quotient;
                    default: ;
                endcase
            end
            OP_MARK_INIT: ptr_reg <= y0_reg[ROW_W-1:0];
            OP_MARK_WR:   ptr_reg <= ptr_reg + 1'b1;
            OP_SCAN_INIT:
            begin
                a_reg   <= '0;
                b_reg   <= '0;
                r_reg   <= '0;
                run_reg <= '0;
                acc_reg <= '0;
            end
            OP_ACC_OR:
            begin
                acc_reg <= acc_reg | rowdata;
                r_reg   <= r_reg + 1'b1;
                a_reg   <= '0;
            end
            OP_WIN_FOUND:
            begin
                x0_reg  <= SUM_W'(a_reg);
                x1_reg  <= SUM_W'(a_reg) + wa_reg;
                y0_reg  <= SUM_W'(b_reg);
                y1_reg  <= SUM_W'(b_reg) + ha_reg;
                ptr_reg <= b_reg;
            end
            OP_NEXT_A: a_reg <= a_reg + 1'b1;
            OP_NEXT_B:
            begin
                b_reg   <= b_reg + 1'b1;
                r_reg   <= b_reg + 1'b1;
                acc_reg <= '0;
            end
            OP_COL_STEP:
            begin
                run_reg <= sts.row_free ? run_reg + 1'b1 : '0;
                r_reg   <= r_reg + 1'b1;
            end
            OP_COL_FOUND:
            begin
                x0_reg  <= SUM_W'(a_reg);
                x1_reg  <= SUM_W'(a_reg) + wa_reg;
                y0_reg  <= SUM_W'(r_reg) - ha_reg;
                y1_reg  <= SUM_W'(r_reg);
                ptr_reg <= r_reg - ha_reg[ROW_W-1:0];
            end
            OP_NEXT_COL:
            begin
                a_reg   <= a_reg + 1'b1;
                r_reg   <= '0;
                run_reg <= '0;
            end
            OP_FINISH:
            begin
                out_status_reg <= status_reg;
                if (status_reg == STATUS_DONE && item_reg.mode)
                begin
                    out_left_reg <= place_pix(x0_reg[COL_W-1:0], spacing_reg, area_left_reg);
                    out_top_reg  <= place_pix(y0_reg[COL_W-1:0], spacing_reg, area_top_reg);
                end
                else
                begin
                    out_left_reg <= '0;
                    out_top_reg  <= '0;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        sts.s_zero    = spacing_reg == '0;
        sts.div_done  = div_done;
        sts.mode      = item_reg.mode;
        sts.fresh     = item_reg.new_layout;
        sts.order     = order_reg;
        sts.neg       = (item_reg.rect_left < area_left_reg) ||
                        (item_reg.rect_top < area_top_reg);
        sts.empty     = (x1_reg < x0_reg) || (y1_reg < y0_reg);
        sts.oob       = (x1_reg >= SUM_W'(cols_reg)) || (y1_reg >= SUM_W'(rows_reg));
        sts.no_room   = (wa_reg >= SUM_W'(cols_reg)) || (ha_reg >= SUM_W'(rows_reg));
        sts.acc_free  = window_free(acc_reg, a_reg, wa_n);
        sts.row_free  = window_free(rowdata, a_reg, wa_n);
        sts.r_at_end  = CNT_W'(r_reg) == CNT_W'(b_reg) + ha_n;
        sts.a_last    = CNT_W'(a_reg) + wa_n == cols_reg - 1'b1;
        sts.b_last    = CNT_W'(b_reg) + ha_n == rows_reg - 1'b1;
        sts.r_last    = CNT_W'(r_reg) == rows_reg - 1'b1;
        sts.run_hit   = run_reg == ha_n;
        sts.mark_last = ptr_reg == y1_reg[ROW_W-1:0];
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_left   = out_left_reg;
    assign out_top    = out_top_reg;
endmodule

>>> hdl/gffp_ctrl.sv
// Controller: sequences divisions, range checks, marking and the first-fit scan.
// Depends on gffp_pkg and the assertion macro header.
`include "grid_first_fit_placement_defines.svh"

module gffp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  gffp_pkg::sts_t sts,
    output gffp_pkg::cmd_t cmd
);
    import gffp_pkg::*;

    localparam int SW = 4;
    localparam logic [SW-1:0] ST_IDLE     = 4'd0;
    localparam logic [SW-1:0] ST_CHECK    = 4'd1;
    localparam logic [SW-1:0] ST_DIV_GO   = 4'd2;
    localparam logic [SW-1:0] ST_DIV_WAIT = 4'd3;
    localparam logic [SW-1:0] ST_EVAL     = 4'd4;
    localparam logic [SW-1:0] ST_MARK_RD  = 4'd5;
    localparam logic [SW-1:0] ST_MARK_WR  = 4'd6;
    localparam logic [SW-1:0] ST_ACC_RD   = 4'd7;
    localparam logic [SW-1:0] ST_ACC_OR   = 4'd8;
    localparam logic [SW-1:0] ST_WIN      = 4'd9;
    localparam logic [SW-1:0] ST_COL_RD   = 4'd10;
    localparam logic [SW-1:0] ST_COL_CHK  = 4'd11;
    localparam logic [SW-1:0] ST_FINISH   = 4'd12;

    logic [SW-1:0]     state_reg, state_next;
    logic [DSEL_W-1:0] k_reg, k_next;
    logic [DSEL_W-1:0] k_first, k_after;
    logic              k_last;

    // division order: grid size on a new layout, then the item's own quotients
    always_comb
    begin
        k_first = sts.fresh ? DIV_AW : (sts.mode ? DIV_RW : DIV_DX);
        k_last  = 1'b0;
        case (k_reg)
            DIV_AW:  k_after = DIV_AH;
            DIV_AH:  k_after = sts.mode ? DIV_RW : DIV_DX;
            DIV_DX:  k_after = DIV_EX;
            DIV_EX:  k_after = DIV_DY;
            DIV_DY:  k_after = DIV_EY;
            DIV_RW:  k_after = DIV_RH;
            default:
            begin
                k_after = k_reg;
                k_last  = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        cmd.op        = OP_NONE;
        cmd.dsel      = k_reg;
        cmd.status_we = 1'b0;
        cmd.status    = STATUS_DONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.s_zero)
                begin
                    cmd.status_we = 1'b1;
                    cmd.status    = STATUS_RANGE;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    k_next     = k_first;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                cmd.op     = OP_DIV_START;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.op = OP_DIV_STORE;
                    if (k_last)
                    begin
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        k_next     = k_after;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_EVAL:
            begin
                if (!sts.mode)
                begin
                    if (sts.neg || (!sts.empty && sts.oob))
                    begin
                        cmd.status_we = 1'b1;
                        cmd.status    = STATUS_RANGE;
                        state_next    = ST_FINISH;
                    end
                    else if (sts.empty)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.op     = OP_MARK_INIT;
                        state_next = ST_MARK_RD;
                    end
                end
                else if (sts.no_room)
                begin
                    cmd.status_we = 1'b1;
                    cmd.status    = STATUS_NOROOM;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    cmd.op     = OP_SCAN_INIT;
                    state_next = sts.order ? ST_COL_RD : ST_ACC_RD;
                end
            end
            ST_MARK_RD:
            begin
                cmd.op     = OP_MARK_RD;
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR:
            begin
                cmd.op     = OP_MARK_WR;
                state_next = sts.mark_last ? ST_FINISH : ST_MARK_RD;
            end
            ST_ACC_RD:
            begin
                cmd.op     = OP_ACC_RD;
                state_next = ST_ACC_OR;
            end
            ST_ACC_OR:
            begin
                cmd.op     = OP_ACC_OR;
                state_next = sts.r_at_end ? ST_WIN : ST_ACC_RD;
            end
            ST_WIN:
            begin
                if (sts.acc_free)
                begin
                    cmd.op     = OP_WIN_FOUND;
                    state_next = ST_MARK_RD;
                end
                else if (!sts.a_last)
                begin
                    cmd.op = OP_NEXT_A;
                end
                else if (sts.b_last)
                begin
                    cmd.status_we = 1'b1;
                    cmd.status    = STATUS_NOROOM;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    cmd.op     = OP_NEXT_B;
                    state_next = ST_ACC_RD;
                end
            end
            ST_COL_RD:
            begin
                cmd.op     = OP_COL_RD;
                state_next = ST_COL_CHK;
            end
            ST_COL_CHK:
            begin
                if (sts.row_free && sts.run_hit)
                begin
                    cmd.op     = OP_COL_FOUND;
                    state_next = ST_MARK_RD;
                end
                else if (!sts.r_last)
                begin
                    cmd.op     = OP_COL_STEP;
                    state_next = ST_COL_RD;
                end
                else if (sts.a_last)
                begin
                    cmd.status_we = 1'b1;
                    cmd.status    = STATUS_NOROOM;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    cmd.op     = OP_NEXT_COL;
                    state_next = ST_COL_RD;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= DIV_AW;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    assign in_ready = state_reg == ST_IDLE;

    `GFFP_ASSERT_SAME(a_store_on_done, cmd.op == OP_DIV_STORE, sts.div_done, "quotient stored early")
    `GFFP_ASSERT_NEXT(a_accept_check, in_valid && in_ready, state_reg == ST_CHECK, "accept lost")
    `GFFP_ASSERT_NEXT(a_mark_flow, state_reg == ST_MARK_WR, state_reg == ST_MARK_RD || state_reg == ST_FINISH, "mark sequence broken")
endmodule
